@@ rtl/lfu_pkg.sv @@
// Package: shared types and codes for the LFU cache table.
package lfu_pkg;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] lookup_key;
      logic signed [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
   } rsp_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic        clear;   // clear of all valid bits (the controller never issues it)
      logic        touch;   // promote the hit entry, age the more recent ones
      logic        evict;   // invalidate the victim, close the rank gap
      logic        insert;  // age all valid entries, fill the free slot
      logic        wr_val;  // overwrite value of the hit entry
   } cell_cmd_type;

endpackage

@@ rtl/lfu_cell.sv @@
// One storage cell: key, value, use count and recency rank of one slot.
module lfu_cell #(
   parameter int COUNT_BITS = 16,
   parameter int RANK_BITS  = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lfu_pkg::cell_cmd_type     cmd,
   input  logic                      sel,        // this cell is the target slot
   input  logic [31:0]               cmd_key,
   input  logic [31:0]               cmd_value,
   input  logic [RANK_BITS-1:0]      cmd_rank,   // rank of the target before the op
   output logic                      valid,
   output logic [31:0]               key,
   output logic [31:0]               value,
   output logic [COUNT_BITS-1:0]     count,
   output logic [RANK_BITS-1:0]      rank
);

   logic                  valid_ff, valid_in;
   logic [31:0]           key_ff, key_in;
   logic [31:0]           value_ff, value_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [RANK_BITS-1:0]  rank_ff, rank_in;

   // Apply the broadcast command to this slot
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.touch) begin
         if (sel) begin
            rank_in = '0;
            if (count_ff != {COUNT_BITS{1'b1}}) begin
               count_in = count_ff + 1'b1;
            end
            if (cmd.wr_val) begin
               value_in = cmd_value;
            end
         end else if (valid_ff && rank_ff < cmd_rank) begin
            rank_in = rank_ff + 1'b1;
         end
      end else if (cmd.evict) begin
         if (sel) begin
            valid_in = 1'b0;
         end else if (valid_ff && rank_ff > cmd_rank) begin
            rank_in = rank_ff - 1'b1;
         end
      end else if (cmd.insert) begin
         if (sel) begin
            valid_in = 1'b1;
            key_in   = cmd_key;
            value_in = cmd_value;
            count_in = {{(COUNT_BITS-1){1'b0}}, 1'b1};
            rank_in  = '0;
         end else if (valid_ff) begin
            rank_in = rank_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
      count_ff <= count_in;
      rank_ff  <= rank_in;
   end

   assign valid = valid_ff;
   assign key   = key_ff;
   assign value = value_ff;
   assign count = count_ff;
   assign rank  = rank_ff;

endmodule

@@ rtl/lfu_cache_table_top.sv @@
// Top level: controller that scans a row of LFU cells one slot per cycle.
//
//   channel | direction | handshake          | payload
//   req     | in        | start / busy       | req_data  (lfu_pkg::req_type)
//   rsp     | out       | rsp_valid strobe   | rsp_data  (lfu_pkg::rsp_type)
//   csr     | in        | csr_valid/csr_ready| csr_data  (capacity_in_use, 5 bits)
//
// Each request scans all CAPACITY slots, one per cycle, for the key, the victim
// and the first free slot; then an evict and an insert state, an insert state
// or a touch state as needed, and a response state.
// Synchronous reset clears valid bits, occupancy and the controller.
// The response strobe lasts one cycle; the receiver cannot stall it.
module lfu_cache_table_top #(
   parameter int CAPACITY   = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lfu_pkg::req_type req_data,
   output logic             rsp_valid,
   output lfu_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [4:0]       csr_data
);

   localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_BITS = IDX_BITS;
   localparam int OCC_BITS  = $clog2(CAPACITY + 1);
   localparam int LIM_BITS  = (OCC_BITS > 5) ? OCC_BITS : 5;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_EVICT  = 3'd2;
   localparam logic [2:0] ST_INSERT = 3'd3;
   localparam logic [2:0] ST_TOUCH  = 3'd4;
   localparam logic [2:0] ST_RESP   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   lfu_pkg::req_type      req_ff, req_in;
   logic [4:0]            cap_ff, cap_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   logic                  hit_ff, hit_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [31:0]           hit_val_ff, hit_val_in;
   logic [RANK_BITS-1:0]  hit_rank_ff, hit_rank_in;
   logic                  vic_ok_ff, vic_ok_in;
   logic [IDX_BITS-1:0]   vic_idx_ff, vic_idx_in;
   logic [COUNT_BITS-1:0] vic_cnt_ff, vic_cnt_in;
   logic [RANK_BITS-1:0]  vic_rank_ff, vic_rank_in;
   logic                  free_ok_ff, free_ok_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lfu_pkg::rsp_type      rsp_ff, rsp_in;

   lfu_pkg::cell_cmd_type cmd;
   logic [IDX_BITS-1:0]   tgt_idx;
   logic [RANK_BITS-1:0]  tgt_rank;

   logic                  c_valid [CAPACITY];
   logic [31:0]           c_key   [CAPACITY];
   logic [31:0]           c_value [CAPACITY];
   logic [COUNT_BITS-1:0] c_count [CAPACITY];
   logic [RANK_BITS-1:0]  c_rank  [CAPACITY];

   // Cell row
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      lfu_cell #(.COUNT_BITS(COUNT_BITS), .RANK_BITS(RANK_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .sel      (tgt_idx == IDX_BITS'(g)),
         .cmd_key  (req_ff.lookup_key),
         .cmd_value(req_ff.write_value),
         .cmd_rank (tgt_rank),
         .valid    (c_valid[g]),
         .key      (c_key[g]),
         .value    (c_value[g]),
         .count    (c_count[g]),
         .rank     (c_rank[g])
      );
   end

   // Slot under scan
   logic                  s_valid;
   logic [31:0]           s_key, s_value;
   logic [COUNT_BITS-1:0] s_count;
   logic [RANK_BITS-1:0]  s_rank;
   logic [LIM_BITS-1:0]   limit;
   logic                  last;

   always_comb begin
      s_valid = c_valid[idx_ff];
      s_key   = c_key[idx_ff];
      s_value = c_value[idx_ff];
      s_count = c_count[idx_ff];
      s_rank  = c_rank[idx_ff];
      limit   = (LIM_BITS'(cap_ff) < LIM_BITS'(CAPACITY)) ? LIM_BITS'(cap_ff)
                                                          : LIM_BITS'(CAPACITY);
      last    = (idx_ff == IDX_BITS'(CAPACITY - 1));
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      req_in       = req_ff;
      cap_in       = cap_ff;
      occ_in       = occ_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_val_in   = hit_val_ff;
      hit_rank_in  = hit_rank_ff;
      vic_ok_in    = vic_ok_ff;
      vic_idx_in   = vic_idx_ff;
      vic_cnt_in   = vic_cnt_ff;
      vic_rank_in  = vic_rank_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd          = '0;
      tgt_idx      = hit_idx_ff;
      tgt_rank     = hit_rank_ff;

      if (csr_valid && state_ff == ST_IDLE) begin
         cap_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in     = req_data;
               idx_in     = '0;
               hit_in     = 1'b0;
               vic_ok_in  = 1'b0;
               free_ok_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // track hit, victim, first free slot
            if (s_valid && s_key == req_ff.lookup_key && !hit_ff) begin
               hit_in      = 1'b1;
               hit_idx_in  = idx_ff;
               hit_val_in  = s_value;
               hit_rank_in = s_rank;
            end
            if (s_valid && (!vic_ok_ff || s_count < vic_cnt_ff ||
                (s_count == vic_cnt_ff && s_rank > vic_rank_ff))) begin
               vic_ok_in   = 1'b1;
               vic_idx_in  = idx_ff;
               vic_cnt_in  = s_count;
               vic_rank_in = s_rank;
            end
            if (!s_valid && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (last) begin
               if (hit_in && (req_ff.opcode == lfu_pkg::OP_GET || limit != '0)) begin
                  state_in = ST_TOUCH;
               end else if (req_ff.opcode == lfu_pkg::OP_PUT && !hit_in &&
                            limit != '0) begin
                  if (LIM_BITS'(occ_ff) >= limit && vic_ok_in) begin
                     state_in = ST_EVICT;
                  end else begin
                     state_in = ST_INSERT;
                  end
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_EVICT: begin
            cmd.evict   = 1'b1;
            tgt_idx     = vic_idx_ff;
            tgt_rank    = vic_rank_ff;
            occ_in      = occ_ff - 1'b1;
            // the evicted slot is now free; keep the lowest free index
            if (!free_ok_ff || vic_idx_ff < free_idx_ff) begin
               free_idx_in = vic_idx_ff;
            end
            free_ok_in  = 1'b1;
            state_in    = ST_INSERT;
         end
         ST_INSERT: begin
            if (free_ok_ff) begin
               cmd.insert = 1'b1;
               tgt_idx    = free_idx_ff;
               occ_in     = occ_ff + 1'b1;
            end
            state_in = ST_RESP;
         end
         ST_TOUCH: begin
            cmd.touch  = 1'b1;
            cmd.wr_val = (req_ff.opcode == lfu_pkg::OP_PUT);
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in      = 1'b1;
            rsp_in.found      = hit_ff;
            rsp_in.read_value = (hit_ff && req_ff.opcode == lfu_pkg::OP_GET)
                                ? hit_val_ff : 32'sd0;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= 5'd16;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      req_ff      <= req_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      hit_rank_ff <= hit_rank_in;
      vic_ok_ff   <= vic_ok_in;
      vic_idx_ff  <= vic_idx_in;
      vic_cnt_ff  <= vic_cnt_in;
      vic_rank_ff <= vic_rank_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/lfu_checker.sv @@
// Checker: port-level properties of the LFU cache table, bound to the top level.
module lfu_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input lfu_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready
);

   // accepted request makes the block busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");

   // response strobe comes only after busy and lasts one cycle
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("response without request");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response longer than one cycle");

   // a miss never returns data
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> rsp_data.read_value == 32'sd0)
      else $error("miss with data");

   // csr is taken only when idle
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !busy) else $error("csr taken while busy");

endmodule

bind lfu_cache_table_top lfu_checker u_lfu_checker (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid),
   .rsp_data (rsp_data),
   .csr_valid(csr_valid),
   .csr_ready(csr_ready)
);

@@ tb/sv/lfu_cache_table_top_tb.sv @@
// Testbench for the LFU cache table: directed table and capacity cases, then random get/put traffic.
`timescale 1ns / 1ps

module lfu_cache_table_top_tb;

   localparam int SLOTS      = 16;
   localparam int COUNT_BITS = 16;
   localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HAMMER_GETS  = 20;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   lfu_pkg::req_type req_data;
   logic             rsp_valid;
   lfu_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [4:0]       csr_data;

   lfu_cache_table_top #(.CAPACITY(SLOTS), .COUNT_BITS(COUNT_BITS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Shadow copy of the cache state
   logic [4:0]  cap_reg;
   logic        slot_valid [SLOTS];
   logic [31:0] slot_key   [SLOTS];
   logic [31:0] slot_value [SLOTS];
   int unsigned slot_uses  [SLOTS];
   int unsigned slot_rank  [SLOTS];
   int unsigned occupancy;

   lfu_pkg::rsp_type pending_rsp [$];
   int          mismatches;
   int          requests_sent;
   int          responses_seen;
   int          hits_seen;
   longint      cycle_count;
   bit          steady;   // no idling in this stretch

   typedef struct {
      logic        op;
      logic [31:0] key;
      logic [31:0] value;
      bit          typed;   // expected response given in the row
      logic        exp_found;
      logic [31:0] exp_value;
   } lookup_row_type;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Make slot s the most recently used
   function automatic void promote(int s);
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s])
            slot_rank[i]++;
      slot_rank[s] = 0;
      if (slot_uses[s] < COUNT_MAX)
         slot_uses[s]++;
   endfunction

   // Apply one request to the shadow state and return the response it gives
   function automatic lfu_pkg::rsp_type cache_access(lfu_pkg::req_type rq);
      lfu_pkg::rsp_type rs;
      int          hit;
      int          victim;
      int          free_slot;
      int unsigned limit;
      int unsigned vr;
      hit = -1;
      rs.found = 1'b0;
      rs.read_value = '0;
      limit = (cap_reg < SLOTS) ? cap_reg : SLOTS;
      for (int i = 0; i < SLOTS; i++)
         if (hit < 0 && slot_valid[i] && slot_key[i] == rq.lookup_key)
            hit = i;
      rs.found = (hit >= 0);
      if (rq.opcode == lfu_pkg::OP_GET) begin
         if (hit >= 0) begin
            rs.read_value = slot_value[hit];
            promote(hit);
         end
      end else if (limit != 0) begin
         if (hit >= 0) begin
            slot_value[hit] = rq.write_value;
            promote(hit);
         end else begin
            if (occupancy >= limit) begin
               victim = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!slot_valid[i])
                     continue;
                  if (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                      (slot_uses[i] == slot_uses[victim] &&
                       slot_rank[i] > slot_rank[victim]))
                     victim = i;
               end
               if (victim >= 0) begin
                  vr = slot_rank[victim];
                  slot_valid[victim] = 1'b0;
                  for (int i = 0; i < SLOTS; i++)
                     if (slot_valid[i] && slot_rank[i] > vr)
                        slot_rank[i]--;
                  occupancy--;
               end
            end
            free_slot = -1;
            for (int i = 0; i < SLOTS; i++)
               if (free_slot < 0 && !slot_valid[i])
                  free_slot = i;
            if (free_slot >= 0) begin
               for (int i = 0; i < SLOTS; i++)
                  if (slot_valid[i])
                     slot_rank[i]++;
               slot_valid[free_slot] = 1'b1;
               slot_key[free_slot]   = rq.lookup_key;
               slot_value[free_slot] = rq.write_value;
               slot_uses[free_slot]  = 1;
               slot_rank[free_slot]  = 0;
               occupancy++;
            end
         end
      end
      return rs;
   endfunction

   // Check each response strobe against the oldest pending one
   always @(posedge clock) begin
      lfu_pkg::rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         responses_seen <= responses_seen + 1;
         if (rsp_data.found)
            hits_seen <= hits_seen + 1;
         if (pending_rsp.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected response found=%0b value=%0d",
                        rsp_data.found, rsp_data.read_value);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.found !== want.found || rsp_data.read_value !== want.read_value) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("response mismatch: found exp %0b got %0b, value exp %0d got %0d",
                           want.found, rsp_data.found, want.read_value,
                           rsp_data.read_value);
            end
         end
      end
   end

   // Abort on runaway
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("lfu_cache_table_top_tb: errors");
         $finish;
      end
   end

   // Random idle before a request, except in a steady stretch
   task automatic idle_gap();
      while (!steady && $urandom_range(0, 99) < 8)
         @(posedge clock);
   endtask

   // Send one request; predict when it is accepted
   task automatic send_request(lfu_pkg::req_type rq, bit typed, logic exp_found,
                               logic [31:0] exp_value);
      lfu_pkg::rsp_type want;
      idle_gap();
      start    <= 1'b1;
      req_data <= rq;
      do
         @(posedge clock);
      while (busy);
      want = cache_access(rq);
      if (typed && (want.found !== exp_found || want.read_value !== exp_value))
         $display("table row disagrees with predictor for key %0d", rq.lookup_key);
      if (typed) begin
         want.found = exp_found;
         want.read_value = exp_value;
      end
      pending_rsp.push_back(want);
      requests_sent++;
      // drop start; the block is busy through the next edge anyway
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Drain outstanding responses, then write the capacity register
   task automatic set_capacity(logic [4:0] value);
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      cap_reg = value;
      csr_valid <= 1'b0;
   endtask

   function automatic lfu_pkg::req_type make_req(logic op, logic [31:0] key,
                                                 logic [31:0] value);
      lfu_pkg::req_type rq;
      rq.opcode = op;
      rq.lookup_key = key;
      rq.write_value = value;
      return rq;
   endfunction

   // Keys from a small pool so gets hit and puts evict
   task automatic random_phase(int count, int key_pool);
      lfu_pkg::req_type rq;
      logic [31:0]      key;
      for (int n = 0; n < count; n++) begin
         steady = (n >= count / 2) && (n < count / 2 + count / 5);
         if ($urandom_range(0, 9) == 0)
            key = $urandom();
         else
            key = 32'(int'($urandom_range(0, key_pool - 1)) - key_pool / 2);
         rq = make_req(1'($urandom_range(0, 1)), key, $urandom());
         send_request(rq, 1'b0, 1'b0, '0);
      end
      steady = 1'b0;
   endtask

   lookup_row_type directed_rows [$];

   function automatic lookup_row_type row(logic op, logic [31:0] key, logic [31:0] value,
                                          bit typed, logic f, logic [31:0] v);
      lookup_row_type r;
      r.op = op; r.key = key; r.value = value;
      r.typed = typed; r.exp_found = f; r.exp_value = v;
      return r;
   endfunction

   initial begin
      lfu_pkg::req_type rq;
      clock = 1'b0;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      reset = 1'b1;
      steady = 1'b0;
      mismatches = 0;
      requests_sent = 0;
      responses_seen = 0;
      hits_seen = 0;
      cycle_count = 0;
      cap_reg = 5'd16;
      occupancy = 0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid[i] = 1'b0; slot_key[i] = '0; slot_value[i] = '0;
         slot_uses[i] = 0; slot_rank[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store, key and value extremes, hit, update, miss
      directed_rows.push_back(row(lfu_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF,
                                  1'b1, 1'b0, 32'h0));
      directed_rows.push_back(row(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF,
                                  1'b1, 1'b0, 32'h0));
      directed_rows.push_back(row(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000,
                                  1'b1, 1'b0, 32'h0));
      directed_rows.push_back(row(lfu_pkg::OP_GET, 32'h8000_0000, 32'h0,
                                  1'b1, 1'b1, 32'h7FFF_FFFF));
      directed_rows.push_back(row(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0,
                                  1'b1, 1'b1, 32'h8000_0000));
      directed_rows.push_back(row(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                  1'b1, 1'b1, 32'h0));
      directed_rows.push_back(row(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0,
                                  1'b1, 1'b1, 32'hFFFF_FFFF));
      directed_rows.push_back(row(lfu_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0,
                                  1'b1, 1'b0, 32'h0));
      directed_rows.push_back(row(lfu_pkg::OP_PUT, 32'h0000_0000, 32'h0,
                                  1'b0, 1'b0, 32'h0));
      for (int i = 0; i < directed_rows.size(); i++) begin
         rq = make_req(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value);
         send_request(rq, directed_rows[i].typed, directed_rows[i].exp_found,
                      directed_rows[i].exp_value);
      end

      // Capacity 2: eviction by count, ties by recency
      set_capacity(5'd2);
      for (int i = 0; i < 8; i++)
         send_request(make_req(i % 3 == 2 ? lfu_pkg::OP_GET : lfu_pkg::OP_PUT,
                               32'(i % 4), 32'(i * 7)),
                      1'b0, 1'b0, '0);

      // Zero capacity: a put is ignored, so the get after it misses
      set_capacity(5'd0);
      send_request(make_req(lfu_pkg::OP_PUT, 32'd1234, 32'd5), 1'b0, 1'b0, '0);
      send_request(make_req(lfu_pkg::OP_GET, 32'd1234, 32'd0), 1'b1, 1'b0, 32'h0);

      // Random phases across capacity settings, extremes included
      set_capacity(5'd31);
      random_phase(200, 24);
      set_capacity(5'd1);
      random_phase(80, 4);
      set_capacity(5'd0);
      random_phase(60, 24);
      set_capacity(5'd5);
      random_phase(150, 10);
      set_capacity(5'd16);
      random_phase(150, 40);
      set_capacity(5'd3);   // below occupancy: entries kept until evicted
      random_phase(100, 8);
      set_capacity(5'd17);
      // Hammer one key so its use count stands well above the rest
      send_request(make_req(lfu_pkg::OP_PUT, 32'd99, 32'd1), 1'b0, 1'b0, '0);
      steady = 1'b1;
      for (int i = 0; i < HAMMER_GETS; i++)
         send_request(make_req(lfu_pkg::OP_GET, 32'd99, 32'd0), 1'b0, 1'b0, '0);
      steady = 1'b0;
      random_phase(100, 30);

      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests sent, %0d responses checked, %0d hits, capacities 0 to 31",
               requests_sent, responses_seen, hits_seen);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("lfu_cache_table_top_tb: clean");
      else begin
         $display("%0d mismatches", mismatches);
         $display("lfu_cache_table_top_tb: errors");
      end
      $finish;
   end

endmodule

@@ lfu_cache_table_top.f @@
rtl/lfu_pkg.sv
rtl/lfu_cell.sv
rtl/lfu_cache_table_top.sv
rtl/lfu_checker.sv
tb/sv/lfu_cache_table_top_tb.sv
